@@ rtl/core/spam_pkg.sv @@
// Shared constants, codes and types of the sparse polynomial arithmetic block.
package spam_pkg;

  localparam int MAX_TERMS  = 8;
  localparam int STORE_AW   = 3;
  localparam int CNT_W      = 4;
  localparam int RES_DEPTH  = 64;
  localparam int RES_AW     = 6;
  localparam int RCNT_W     = 7;
  localparam int COEF_W     = 32;
  localparam int TEXP_W     = 15;
  localparam int REXP_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMBINE   = 2'd1;

  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [COEF_W-1:0] a;
    logic [COEF_W-1:0] b;
  } alu_req_t;

endpackage

@@ rtl/core/spam_if.sv @@
// Handshake interfaces for term words, result words and configuration writes.
interface spam_term_if;
  logic                                valid;
  logic                                ready;
  logic                                which_operand;
  logic signed [spam_pkg::COEF_W-1:0] term_coefficient;
  logic        [spam_pkg::TEXP_W-1:0] term_exponent;
  logic                                last_term;
  modport source (output valid, which_operand, term_coefficient, term_exponent, last_term,
                  input ready);
  modport sink   (input valid, which_operand, term_coefficient, term_exponent, last_term,
                  output ready);
endinterface

interface spam_result_if;
  logic                                valid;
  logic                                ready;
  logic signed [spam_pkg::COEF_W-1:0] result_coefficient;
  logic        [spam_pkg::REXP_W-1:0] result_exponent;
  logic                                last_result;
  modport source (output valid, result_coefficient, result_exponent, last_result,
                  input ready);
  modport sink   (input valid, result_coefficient, result_exponent, last_result,
                  output ready);
endinterface

interface spam_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [spam_pkg::CFG_IDX_W-1:0]      index;
  logic [spam_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/spam_alu.sv @@
// Shared coefficient unit: add, subtract or wrapped multiply, result registered.
module spam_alu (
  input  logic                        clk,
  input  spam_pkg::alu_req_t          req,
  output logic [spam_pkg::COEF_W-1:0] res
);

  logic [spam_pkg::COEF_W-1:0] res_next;

  always_comb begin
    case (req.op)
      spam_pkg::ALU_ADD: res_next = req.a + req.b;
      spam_pkg::ALU_SUB: res_next = req.a - req.b;
      spam_pkg::ALU_MUL: res_next = spam_pkg::COEF_W'(req.a * req.b);
      default:           res_next = req.a;
    endcase
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule

@@ rtl/core/spam_engine.sv @@
// Operand stores, result memory and the sequencer that drives the shared unit.
module spam_engine (
  input  logic                        clk,
  input  logic                        rst,
  spam_term_if.sink                   term,
  spam_result_if.source               result,
  spam_cfg_if.sink                    cfg,
  output spam_pkg::alu_req_t          req,
  input  logic [spam_pkg::COEF_W-1:0] alu_res
);

  typedef enum logic [10:0] {
    S_LOAD  = 11'b00000000001,
    S_MERGE = 11'b00000000010,
    S_MUL   = 11'b00000000100,
    S_MWR   = 11'b00000001000,
    S_CI    = 11'b00000010000,
    S_CIR   = 11'b00000100000,
    S_CJ    = 11'b00001000000,
    S_CJR   = 11'b00010000000,
    S_CJA   = 11'b00100000000,
    S_OUT   = 11'b01000000000,
    S_ORD   = 11'b10000000000
  } state_t;

  state_t state;

  logic [1:0] operation;
  logic       combine;

  logic [spam_pkg::COEF_W-1:0] fc [spam_pkg::MAX_TERMS];
  logic [spam_pkg::TEXP_W-1:0] fe [spam_pkg::MAX_TERMS];
  logic [spam_pkg::COEF_W-1:0] sc [spam_pkg::MAX_TERMS];
  logic [spam_pkg::TEXP_W-1:0] se [spam_pkg::MAX_TERMS];
  logic [spam_pkg::CNT_W-1:0]  fcnt, scnt, i, j;

  logic [spam_pkg::COEF_W+spam_pkg::REXP_W-1:0] mem [spam_pkg::RES_DEPTH];
  logic [spam_pkg::COEF_W+spam_pkg::REXP_W-1:0] rdata;
  logic [spam_pkg::RES_AW-1:0]  raddr;
  logic [spam_pkg::RCNT_W-1:0]  n, kept, ci, cj, oi, emitted;
  logic [spam_pkg::RES_DEPTH-1:0] removed;
  logic [spam_pkg::REXP_W-1:0]  exp_hold, ei;
  logic [spam_pkg::COEF_W-1:0]  acc;

  logic ovalid, olast;
  logic [spam_pkg::COEF_W-1:0] ocoef;
  logic [spam_pkg::REXP_W-1:0] oexp;

  logic term_acc, out_acc, out_free;
  logic i_ok, j_ok, take_eq, take_first;
  logic [spam_pkg::COEF_W-1:0] r_coef;
  logic [spam_pkg::REXP_W-1:0] r_exp;

  assign term.ready = (state == S_LOAD);
  assign cfg.ready  = 1'b1;
  assign term_acc   = term.valid && term.ready;
  assign out_acc    = ovalid && result.ready;
  assign out_free   = !ovalid || out_acc;

  assign result.valid              = ovalid;
  assign result.result_coefficient = ocoef;
  assign result.result_exponent    = oexp;
  assign result.last_result        = olast;

  assign i_ok       = (i < fcnt);
  assign j_ok       = (j < scnt);
  assign take_eq    = i_ok && j_ok && (fe[i[2:0]] == se[j[2:0]]);
  assign take_first = !j_ok || (i_ok && (fe[i[2:0]] > se[j[2:0]]));
  assign r_coef     = rdata[spam_pkg::COEF_W+spam_pkg::REXP_W-1:spam_pkg::REXP_W];
  assign r_exp      = rdata[spam_pkg::REXP_W-1:0];

  always_comb begin
    req.op = spam_pkg::ALU_ADD;
    req.a  = '0;
    req.b  = '0;
    case (state)
      S_MERGE: begin
        if (take_eq) begin
          req.op = (operation == spam_pkg::OP_SUB) ? spam_pkg::ALU_SUB : spam_pkg::ALU_ADD;
          req.a  = fc[i[2:0]];
          req.b  = sc[j[2:0]];
        end else if (take_first) begin
          req.a  = fc[i[2:0]];
        end else begin
          req.op = (operation == spam_pkg::OP_SUB) ? spam_pkg::ALU_SUB : spam_pkg::ALU_ADD;
          req.b  = sc[j[2:0]];
        end
      end
      S_MUL: begin
        req.op = spam_pkg::ALU_MUL;
        req.a  = fc[i[2:0]];
        req.b  = sc[j[2:0]];
      end
      S_CJR: begin
        req.a  = acc;
        req.b  = r_coef;
      end
      default: begin
        req.op = spam_pkg::ALU_ADD;
      end
    endcase
  end

  always_comb begin
    case (state)
      S_CJ:    raddr = cj[spam_pkg::RES_AW-1:0];
      S_OUT:   raddr = oi[spam_pkg::RES_AW-1:0];
      default: raddr = ci[spam_pkg::RES_AW-1:0];
    endcase
  end

  // Result memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (state == S_MWR && n < spam_pkg::RCNT_W'(spam_pkg::RES_DEPTH)) begin
      mem[n[spam_pkg::RES_AW-1:0]] <= {alu_res, exp_hold};
    end else if (state == S_CJ && cj >= n) begin
      mem[ci[spam_pkg::RES_AW-1:0]] <= {acc, ei};
    end
  end

  // Operand stores.
  always_ff @(posedge clk) begin
    if (term_acc && !term.which_operand && fcnt < spam_pkg::CNT_W'(spam_pkg::MAX_TERMS)) begin
      fc[fcnt[2:0]] <= term.term_coefficient;
      fe[fcnt[2:0]] <= term.term_exponent;
    end
    if (term_acc && term.which_operand && scnt < spam_pkg::CNT_W'(spam_pkg::MAX_TERMS)) begin
      sc[scnt[2:0]] <= term.term_coefficient;
      se[scnt[2:0]] <= term.term_exponent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      operation <= spam_pkg::OP_ADD;
      combine   <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        spam_pkg::REG_OPERATION: operation <= cfg.data;
        spam_pkg::REG_COMBINE:   combine   <= cfg.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_LOAD;
      fcnt    <= '0;
      scnt    <= '0;
      i       <= '0;
      j       <= '0;
      n       <= '0;
      kept    <= '0;
      ci      <= '0;
      cj      <= '0;
      oi      <= '0;
      emitted <= '0;
      removed <= '0;
      ovalid  <= 1'b0;
    end else begin
      if (out_acc) begin
        ovalid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (term_acc) begin
            if (!term.which_operand) begin
              if (fcnt < spam_pkg::CNT_W'(spam_pkg::MAX_TERMS)) fcnt <= fcnt + 1'b1;
            end else begin
              if (scnt < spam_pkg::CNT_W'(spam_pkg::MAX_TERMS)) scnt <= scnt + 1'b1;
              if (term.last_term) begin
                i       <= '0;
                j       <= '0;
                n       <= '0;
                kept    <= '0;
                removed <= '0;
                state   <= (operation == spam_pkg::OP_MUL) ? S_MUL : S_MERGE;
              end
            end
          end
        end
        S_MERGE: begin
          if (i_ok || j_ok) begin
            if (take_eq) begin
              exp_hold <= {1'b0, fe[i[2:0]]};
              i <= i + 1'b1;
              j <= j + 1'b1;
            end else if (take_first) begin
              exp_hold <= {1'b0, fe[i[2:0]]};
              i <= i + 1'b1;
            end else begin
              exp_hold <= {1'b0, se[j[2:0]]};
              j <= j + 1'b1;
            end
            state <= S_MWR;
          end else begin
            kept    <= n;
            ci      <= '0;
            oi      <= '0;
            emitted <= '0;
            state   <= combine ? S_CI : S_OUT;
          end
        end
        S_MUL: begin
          if (i_ok && scnt != '0) begin
            exp_hold <= {1'b0, fe[i[2:0]]} + {1'b0, se[j[2:0]]};
            if (j + 1'b1 == scnt) begin
              j <= '0;
              i <= i + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
            state <= S_MWR;
          end else begin
            kept    <= n;
            ci      <= '0;
            oi      <= '0;
            emitted <= '0;
            state   <= combine ? S_CI : S_OUT;
          end
        end
        S_MWR: begin
          if (n < spam_pkg::RCNT_W'(spam_pkg::RES_DEPTH)) n <= n + 1'b1;
          state <= (operation == spam_pkg::OP_MUL) ? S_MUL : S_MERGE;
        end
        S_CI: begin
          if (ci >= n) begin
            oi      <= '0;
            emitted <= '0;
            state   <= S_OUT;
          end else if (removed[ci[spam_pkg::RES_AW-1:0]]) begin
            ci <= ci + 1'b1;
          end else begin
            state <= S_CIR;
          end
        end
        S_CIR: begin
          acc   <= r_coef;
          ei    <= r_exp;
          cj    <= ci + 1'b1;
          state <= S_CJ;
        end
        S_CJ: begin
          if (cj >= n) begin
            ci    <= ci + 1'b1;
            state <= S_CI;
          end else begin
            state <= S_CJR;
          end
        end
        S_CJR: begin
          if (!removed[cj[spam_pkg::RES_AW-1:0]] && r_exp == ei) begin
            removed[cj[spam_pkg::RES_AW-1:0]] <= 1'b1;
            kept  <= kept - 1'b1;
            state <= S_CJA;
          end else begin
            cj    <= cj + 1'b1;
            state <= S_CJ;
          end
        end
        S_CJA: begin
          acc   <= alu_res;
          cj    <= cj + 1'b1;
          state <= S_CJ;
        end
        S_OUT: begin
          if (oi >= n) begin
            fcnt  <= '0;
            scnt  <= '0;
            state <= S_LOAD;
          end else if (removed[oi[spam_pkg::RES_AW-1:0]]) begin
            oi <= oi + 1'b1;
          end else if (out_free) begin
            state <= S_ORD;
          end
        end
        S_ORD: begin
          ovalid  <= 1'b1;
          ocoef   <= r_coef;
          oexp    <= r_exp;
          olast   <= (emitted + 1'b1 == kept);
          emitted <= emitted + 1'b1;
          oi      <= oi + 1'b1;
          state   <= S_OUT;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_ord_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_ORD) |-> !ovalid)
    else $error("output register overwritten while still full");

  a_kept_le_n: assert property (@(posedge clk) disable iff (rst)
    kept <= n)
    else $error("kept term count exceeds raw result count");

  a_rise_from_ord: assert property (@(posedge clk) disable iff (rst)
    $rose(ovalid) |-> $past(state == S_ORD))
    else $error("result word raised outside the read-out step");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ORD) |-> (emitted < kept))
    else $error("more result words than kept terms");

endmodule

@@ rtl/core/sparse_polynomial_add_sub_mul.sv @@
// Top level of the sparse polynomial add, subtract and multiply block.
// Terms are loaded one word per cycle, operand 0 first and then operand 1, each of one to
// eight terms in descending exponent order; terms beyond eight in an operand are dropped.
// The word with last_term set on operand 1 starts the configured operation and the block
// stops taking terms until the final result word has been placed in the output register.
// A single shared coefficient unit (adder, subtractor and 32-bit wrapped multiplier) does all
// coefficient arithmetic under a small sequencer. Add and subtract merge the operands, each
// result term (at most sixteen) taking a merge step and a write step; multiply forms every
// pairwise product (at most sixty-four), each taking a product step and a write step. With
// combining enabled, a pass over the result memory follows that compares each surviving term
// with every later one and folds terms of equal exponent into it. Read-out then places each
// kept word in the output register whenever it is free. The final result word carries
// last_result; a multiply with an empty operand gives no words at all. Configuration
// (operation and combine_like_terms) is written through its own port and must only change
// while idle.
module sparse_polynomial_add_sub_mul (
  input  logic          clk,
  input  logic          rst,
  spam_term_if.sink     term,
  spam_result_if.source result,
  spam_cfg_if.sink      cfg
);

  spam_pkg::alu_req_t          req;
  logic [spam_pkg::COEF_W-1:0] alu_res;

  // Sequencer, operand stores and the result memory.
  spam_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .term    (term),
    .result  (result),
    .cfg     (cfg),
    .req     (req),
    .alu_res (alu_res)
  );

  // The one arithmetic unit, shared by merge, product and combining passes.
  spam_alu u_alu (
    .clk (clk),
    .req (req),
    .res (alu_res)
  );

endmodule
